FILE: hdl/qcd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qcd_pkg: shared types and constants for the quadrature click decoder
// Request payloads, command and event codes, the move table, and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package qcd_pkg;

	// request payloads
	typedef struct packed {
		logic [1:0] command;
		logic       pin_a;
		logic       pin_b;
	} qcd_in_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic       last;
	} qcd_out_t;

	// command codes
	localparam logic [1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [1:0] CMD_ENABLE  = 2'd1;
	localparam logic [1:0] CMD_DISABLE = 2'd2;
	localparam logic [1:0] CMD_CLEAR   = 2'd3;

	// event codes
	localparam logic [1:0] EV_CHANGED = 2'd0;
	localparam logic [1:0] EV_RIGHT   = 2'd1;
	localparam logic [1:0] EV_LEFT    = 2'd2;

	// moves per click limits
	localparam logic [6:0] DEFAULT_MPC = 7'd4;
	localparam logic [6:0] MAX_MPC     = 7'd64;

	// controller -> datapath
	typedef struct packed {
		logic take_in;    // apply the accepted request
		logic load_chg;   // load a changed event into the output register
		logic load_click; // load a click event and consume one click
	} qcd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic go_eval;  // accepted request is a sample while running
		logic pending;  // balance holds at least one whole click
		logic out_free; // output register can take a new event
		logic out_last; // event held in the output register is the last one
	} qcd_sts_t;

	// index {B,A current, B,A previous} -> signed move
	function automatic logic signed [2:0] move_of(input logic [3:0] idx);
		logic signed [2:0] mv;
		case (idx)
			4'd0:    mv = 3'sd0;
			4'd1:    mv = 3'sd1;
			4'd2:    mv = -3'sd1;
			4'd3:    mv = 3'sd2;
			4'd4:    mv = -3'sd1;
			4'd5:    mv = 3'sd0;
			4'd6:    mv = -3'sd2;
			4'd7:    mv = 3'sd1;
			4'd8:    mv = 3'sd1;
			4'd9:    mv = -3'sd2;
			4'd10:   mv = 3'sd0;
			4'd11:   mv = -3'sd1;
			4'd12:   mv = 3'sd2;
			4'd13:   mv = -3'sd1;
			4'd14:   mv = 3'sd1;
			default: mv = 3'sd0;
		endcase
		return mv;
	endfunction

endpackage

FILE: hdl/qcd_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qcd_ctrl: sequencing controller
// Accepts one request at a time and steps the datapath through evaluation,
// the changed event and up to two click events.
// ---------------------------------------------------------------------------
module qcd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  qcd_pkg::qcd_sts_t  sts,
	output qcd_pkg::qcd_cmd_t  cmd
);
	import qcd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_CHG  = 4'b0100,
		ST_CLK  = 4'b1000
	} qcd_state_t;

	qcd_state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take_in = 1'b1;
					if (sts.go_eval) begin
						state_d = ST_EVAL;
					end
				end
			end
			ST_EVAL: begin
				if (!sts.pending) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.load_chg = 1'b1;
					state_d      = ST_CHG;
				end
			end
			ST_CHG: begin
				if (sts.out_free) begin
					cmd.load_click = 1'b1;
					state_d        = ST_CLK;
				end
			end
			ST_CLK: begin
				// out_last refers to the click just taken
				if (sts.out_free) begin
					if (sts.out_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.load_click = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/qcd_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qcd_dp: decoder datapath
// Pin history, enable flag, move balance, click size register and the
// output event register.
// ---------------------------------------------------------------------------
module qcd_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  qcd_pkg::qcd_in_t   in_data,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata,
	output logic               out_valid,
	input  logic               out_stall,
	output qcd_pkg::qcd_out_t  out_data,
	input  qcd_pkg::qcd_cmd_t  cmd,
	output qcd_pkg::qcd_sts_t  sts
);
	import qcd_pkg::*;

	logic [6:0]        mpc_q;
	logic [1:0]        hist_q;
	logic              run_q;
	logic signed [7:0] bal_q;
	logic              dir_neg_q;
	logic              second_q;
	logic              out_valid_q;
	qcd_out_t          out_q;

	logic signed [8:0] bal9, mpc9, step9;
	logic              pos, neg, still;
	logic signed [2:0] mv;
	logic              out_take;

	// 9-bit signed compare space; balance stays within +-65
	assign bal9  = {bal_q[7], bal_q};
	assign mpc9  = {2'b00, mpc_q};
	assign pos   = (bal9 >= mpc9);
	assign neg   = ((bal9 + mpc9) <= 9'sd0);
	assign step9 = dir_neg_q ? (bal9 + mpc9) : (bal9 - mpc9);
	assign still = dir_neg_q ? ((step9 + mpc9) <= 9'sd0) : (step9 >= mpc9);

	assign mv       = move_of({in_data.pin_b, in_data.pin_a, hist_q});
	assign out_take = out_valid_q && !out_stall;

	assign sts.go_eval  = (in_data.command == CMD_SAMPLE) && run_q;
	assign sts.pending  = pos || neg;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.out_last = out_q.last;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// click size register, zero reverts to default, saturates at the maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpc_q <= DEFAULT_MPC;
		end else if (cfg_we) begin
			if (cfg_wdata == 7'd0) begin
				mpc_q <= DEFAULT_MPC;
			end else if (cfg_wdata > MAX_MPC) begin
				mpc_q <= MAX_MPC;
			end else begin
				mpc_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q    <= 2'd0;
			run_q     <= 1'b0;
			bal_q     <= 8'sd0;
			dir_neg_q <= 1'b0;
			second_q  <= 1'b0;
		end else begin
			if (cmd.take_in) begin
				case (in_data.command)
					CMD_SAMPLE: begin
						if (run_q) begin
							hist_q <= {in_data.pin_b, in_data.pin_a};
							bal_q  <= bal_q + {{5{mv[2]}}, mv};
						end
					end
					CMD_ENABLE: begin
						hist_q <= {in_data.pin_b, in_data.pin_a};
						run_q  <= 1'b1;
					end
					CMD_DISABLE: begin
						run_q <= 1'b0;
					end
					CMD_CLEAR: begin
						bal_q <= 8'sd0;
					end
					default: begin
						run_q <= run_q;
					end
				endcase
			end
			if (cmd.load_chg) begin
				dir_neg_q <= !pos;
				second_q  <= 1'b0;
			end
			if (cmd.load_click) begin
				bal_q    <= step9[7:0];
				second_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_chg || cmd.load_click) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_chg) begin
			out_q.event_res <= EV_CHANGED;
			out_q.last      <= 1'b0;
		end else if (cmd.load_click) begin
			out_q.event_res <= dir_neg_q ? EV_LEFT : EV_RIGHT;
			out_q.last      <= second_q || !still;
		end
	end

endmodule

FILE: hdl/quadrature_click_decoder_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_click_decoder_unit: quadrature encoder click decoder
// Turns sampled A/B encoder levels into changed / right / left click events.
// ---------------------------------------------------------------------------
// Each request carries a command and the sampled A/B pins. A sample (while
// enabled) forms an index from the previous and current pin pair, looks up a
// move of -2..+2 and adds it to a signed balance. Once the balance reaches
// plus or minus click_size a changed event goes out, then one right or
// left click per whole click consumed, at most two per sample; the final
// event of a request carries last. Enable primes the pin history, disable
// makes samples no-ops, clear zeroes the balance. Requests are handled one
// at a time. The controller emits events one by one through a single
// output register; the next request is taken only once the last event
// has left the output register.
// click_size is written through cfg_we/cfg_wdata, by the user only while idle;
// the block does not enforce it. Zero reverts to 4, values above 64 saturate.
// ---------------------------------------------------------------------------
module quadrature_click_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	// request in
	input  logic               in_valid,
	output logic               in_stall,
	input  qcd_pkg::qcd_in_t   in_data,
	// event out
	output logic               out_valid,
	input  logic               out_stall,
	output qcd_pkg::qcd_out_t  out_data,
	// click_size register
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata
);
	import qcd_pkg::*;

	qcd_cmd_t cmd;
	qcd_sts_t sts;

	// sequencing: idle -> evaluate -> changed -> clicks
	qcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// state, balance arithmetic and output register
	qcd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: hdl/qcd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qcd_checker: port-level checks for the click decoder
// Watches the top-level ports; bound to the top level below.
// ---------------------------------------------------------------------------
module qcd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input qcd_pkg::qcd_out_t  out_data
);
	import qcd_pkg::*;

	// a stalled event holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled event changed");

	// changed is never the final event
	a_chg_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_res == EV_CHANGED |-> !out_data.last)
		else $error("changed event marked last");

	a_ev_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.event_res != 2'd3)
		else $error("unknown event code");

	// no new request while a burst of events is still unfinished
	a_busy_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last |-> in_stall)
		else $error("request taken mid burst");

endmodule

bind quadrature_click_decoder_unit qcd_checker u_qcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

FILE: tb/quadrature_click_decoder_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_click_decoder_unit_test: self-checking bench for the click decoder
// Drives command/pin requests with bursty traffic and random output back-pressure.
// A cycle-free predictor tracks pin history, balance and moves per click.
// Every accepted event is checked against the oldest predicted one.
// ---------------------------------------------------------------------------
module quadrature_click_decoder_unit_test;
	import qcd_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 8;
	localparam int IDLE_TAIL    = 16;   // margin for the worst request to finish
	localparam int WATCHDOG     = 2000; // longer than the longest hold-off
	localparam int MAX_CLICKS   = 2;    // click events per sample at most

	typedef enum logic [1:0] {HEAD_NONE, HEAD_RIGHT, HEAD_LEFT} heading_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	qcd_in_t    in_data;
	logic       out_valid;
	logic       out_stall;
	qcd_out_t   out_data;
	logic       cfg_we;
	logic [6:0] cfg_wdata;

	// predicted decoder state
	logic [6:0]        moves_click = DEFAULT_MPC;
	logic [1:0]        pin_prev    = 2'd0;
	logic              enabled     = 1'b0;
	logic signed [7:0] balance     = '0;
	heading_t          heading     = HEAD_NONE;

	// move for index {current B,A, previous B,A}
	int move_lut [16] = '{0, 1, -1, 2, -1, 0, -2, 1, 1, -2, 0, -1, 2, -1, 1, 0};
	// gray walk order; the table is its own inverse (pins -> position)
	logic [1:0] gray_code [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

	qcd_out_t pending_events [$];

	// traffic shaping
	bit tx_gaps       = 1'b0;
	int burst_left    = 1;
	int stall_pct     = 0;
	int hold_off_len  = 0;

	// bookkeeping
	int fails         = 0;
	int requests_sent = 0;
	int events_seen   = 0;
	int mpc_writes    = 0;
	int holds_done    = 0;
	int quiet_cycles  = 0;
	int walk_pos      = 0;
	int walk_dir      = 1;

	always #(CLK_PERIOD / 2) clk = ~clk;

	quadrature_click_decoder_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// -----------------------------------------------------------------------
	// Predictor: applies one accepted request and queues the events it causes
	// -----------------------------------------------------------------------
	function automatic void predict_clicks(input qcd_in_t req);
		logic [1:0] pins;
		int bal;
		int mpc;
		int clicks;
		qcd_out_t ev;
		pins = {req.pin_b, req.pin_a};
		bal  = int'(balance);
		mpc  = int'(moves_click);
		case (req.command)
			CMD_ENABLE: begin
				pin_prev = pins;
				enabled  = 1'b1;
			end
			CMD_DISABLE: enabled = 1'b0;
			CMD_CLEAR: begin
				balance = '0;
				heading = HEAD_NONE;
			end
			CMD_SAMPLE: begin
				// samples are dropped entirely while disabled
				if (enabled) begin
					bal += move_lut[{pins, pin_prev}];
					pin_prev = pins;
					if (bal >= mpc || -bal >= mpc) begin
						heading = (bal > 0) ? HEAD_RIGHT : HEAD_LEFT;
						ev.last = 1'b0;
						ev.event_res = EV_CHANGED;
						pending_events.push_back(ev);
						ev.event_res = (bal > 0) ? EV_RIGHT : EV_LEFT;
						clicks = 0;
						// whole clicks, two at most; any backlog waits for later samples
						do begin
							pending_events.push_back(ev);
							bal += (bal > 0) ? -mpc : mpc;
							clicks++;
						end while (clicks < MAX_CLICKS && (bal >= mpc || -bal >= mpc));
						ev = pending_events.pop_back();
						ev.last = 1'b1;
						pending_events.push_back(ev);
					end
					balance = 8'(bal);
				end
			end
		endcase
	endfunction

	// -----------------------------------------------------------------------
	// Sender: offers one request, holds it until taken, then maybe gaps
	// -----------------------------------------------------------------------
	task automatic offer_request(input logic [1:0] cmd, input logic [1:0] pins);
		qcd_in_t req;
		req.command = cmd;
		req.pin_a   = pins[0];
		req.pin_b   = pins[1];
		in_data  <= req;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_clicks(req);
		requests_sent++;
		if (tx_gaps) begin
			burst_left--;
			if (burst_left <= 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	// stop offering and wait until every predicted event is out, plus a margin
	// for a request with no events still working its way through
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	// register write, only ever issued on an idle block
	task automatic write_mpc(input logic [6:0] value);
		wait_drained();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		// zero falls back to the default, anything above the ceiling saturates
		if (value == 7'd0)
			moves_click = DEFAULT_MPC;
		else if (value > MAX_MPC)
			moves_click = MAX_MPC;
		else
			moves_click = value;
		mpc_writes++;
	endtask

	// mostly clean gray-code walks, the rest glitches and stray commands
	task automatic send_walk(input int count);
		int pick;
		logic [1:0] pins;
		logic [1:0] cmd;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (!enabled && pick < 60)
				pick = 99; // get back to work soon after a disable
			if (pick < 70) begin
				if ($urandom_range(0, 9) == 0)
					walk_dir = -walk_dir;
				walk_pos = (walk_pos + walk_dir + 4) % 4;
				pins = gray_code[walk_pos[1:0]];
				cmd  = CMD_SAMPLE;
			end else begin
				pins = 2'($urandom_range(0, 3));
				walk_pos = int'(gray_code[pins]);
				if (pick < 82)
					cmd = CMD_SAMPLE;
				else if (pick < 88)
					cmd = CMD_CLEAR;
				else if (pick < 93)
					cmd = CMD_DISABLE;
				else
					cmd = CMD_ENABLE;
			end
			offer_request(cmd, pins);
		end
	endtask

	task automatic run_phase(input logic [6:0] mpc, input bit gaps, input int stall);
		write_mpc(mpc);
		tx_gaps   = gaps;
		stall_pct = stall;
		send_walk(35);
	endtask

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// command set at the default of four moves per click
	task automatic test_commands();
		tx_gaps   = 1'b1;
		stall_pct = 30;
		offer_request(CMD_SAMPLE, 2'd3);  // disabled: dropped
		offer_request(CMD_ENABLE, 2'd3);  // primes history
		offer_request(CMD_SAMPLE, 2'd0);  // +2
		offer_request(CMD_SAMPLE, 2'd3);  // +2: changed, right
		offer_request(CMD_SAMPLE, 2'd2);  // -1
		offer_request(CMD_CLEAR, 2'd1);   // balance back to zero, history kept
		offer_request(CMD_SAMPLE, 2'd1);  // -2
		offer_request(CMD_SAMPLE, 2'd2);  // -2: changed, left
		offer_request(CMD_DISABLE, 2'd0);
		offer_request(CMD_SAMPLE, 2'd3);  // dropped
		offer_request(CMD_ENABLE, 2'd0);
	endtask

	// every previous/current pin pair once, at one move per click so each
	// non-zero move shows up as events
	task automatic test_move_table();
		logic [1:0] walk [16] = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
		                          2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};
		write_mpc(7'd1);
		tx_gaps   = 1'b0;
		stall_pct = 0;
		foreach (walk[i])
			offer_request(CMD_SAMPLE, walk[i]);
	endtask

	// saturation, default fallback, and a click backlog left by lowering the setting
	task automatic test_register_limits();
		tx_gaps   = 1'b1;
		stall_pct = 50;
		write_mpc(7'd127);                // saturates to 64
		offer_request(CMD_CLEAR, 2'd0);
		repeat (2) begin
			offer_request(CMD_SAMPLE, 2'd3);
			offer_request(CMD_SAMPLE, 2'd0);
		end                               // balance 8, well short of a click
		write_mpc(7'd1);
		repeat (4)
			offer_request(CMD_SAMPLE, 2'd0); // no move: backlog drains two a time
		write_mpc(7'd0);                  // back to four
		offer_request(CMD_SAMPLE, 2'd3);
		offer_request(CMD_SAMPLE, 2'd0);
	endtask

	task automatic test_random_phases();
		run_phase(7'd3, 1'b1, 30);
		run_phase(7'd0, 1'b0, 0);          // full rate both ways
		run_phase(7'd64, 1'b1, 50);
		run_phase(7'd1, 1'b1, 20);         // leftovers from 64 become a backlog
		run_phase(7'($urandom_range(1, 127)), 1'b1, 40);
		run_phase(7'd2, 1'b1, 70);
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_hold_off();
		write_mpc(7'd1);
		tx_gaps      = 1'b0;
		stall_pct    = 25;
		hold_off_len = 300;
		offer_request(CMD_ENABLE, 2'd0);
		repeat (15) begin
			offer_request(CMD_SAMPLE, 2'd3);
			offer_request(CMD_SAMPLE, 2'd0);
		end
		wait_drained();
	endtask

	// -----------------------------------------------------------------------
	// Receiver back-pressure: random runs, or one long hold when asked
	// -----------------------------------------------------------------------
	initial begin : rx_pattern
		int run;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_len > 0 && holds_done == 0) begin
				out_stall <= 1'b1;
				repeat (hold_off_len) @(posedge clk);
				holds_done++;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
				run = $urandom_range(1, 6);
				repeat (run) @(posedge clk);
			end
		end
	end

	// -----------------------------------------------------------------------
	// Event checker: each accepted event against the oldest prediction
	// -----------------------------------------------------------------------
	always @(posedge clk) begin : event_check
		qcd_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				$error("event_res: no event expected, got %0d (last %0b)",
				       out_data.event_res, out_data.last);
				fails++;
			end else begin
				want = pending_events.pop_front();
				if (out_data.event_res !== want.event_res) begin
					$error("event_res: expected %0d, got %0d", want.event_res,
					       out_data.event_res);
					fails++;
				end
				if (out_data.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, out_data.last);
					fails++;
				end
			end
			events_seen++;
		end
	end

	// watchdog: too long without any request or event moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("Timeout: no handshake for %0d cycles", WATCHDOG);
			$display("Test completed with failures");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin : run_tests
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands();
		test_move_table();
		test_register_limits();
		test_random_phases();
		test_hold_off();
		wait_drained();

		$display("Run covered %0d requests and %0d events across %0d register writes,",
		         requests_sent, events_seen, mpc_writes);
		$display("with click backlog, saturation, default fallback and %0d long hold-off(s).",
		         holds_done);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
